// ===== rtl/item_key_hash_set_assert.svh =====
// Assertion macros shared by the hash set RTL.
`ifndef ITEM_KEY_HASH_SET_ASSERT_SVH
`define ITEM_KEY_HASH_SET_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IKHS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IKHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ikhs_pkg.sv =====
// Package with types, codes and constants of the key hash set.
package ikhs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int HASH_MULT    = 37;

    localparam int OP_W     = 2;
    localparam int RULE_W   = 12;
    localparam int DOT_W    = 6;
    localparam int KEY_W    = RULE_W + DOT_W;
    localparam int HASH_W   = 18;
    localparam int STATUS_W = 3;
    localparam int OSLOT_W  = 6;
    localparam int OCOUNT_W = 7;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [RULE_W-1:0] rule_index;
        logic [DOT_W-1:0]  dot_position;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OSLOT_W-1:0]  slot;
        logic [OCOUNT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic                accept;
        logic                hash_ld;
        logic                red_step;
        logic                head_rd;
        logic                link_from_head;
        logic                ent_rd;
        logic                link_from_ent;
        logic                hit_ld;
        logic                ins_wr;
        logic                clr_start;
        logic                clr_wr;
        logic                count_clr;
        logic                out_ld;
        logic [STATUS_W-1:0] status;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            red_last;
        logic            link_valid;
        logic            key_match;
        logic            full;
        logic            clr_last;
        logic            out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/ikhs_dp.sv =====
// Datapath of the key hash set: key, hash reduction, memories, count and result register.
module ikhs_dp #(
    parameter int CAPACITY = ikhs_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ikhs_pkg::t_in        i_in,
    input  ikhs_pkg::t_ctrl_cmd  i_cmd,
    output ikhs_pkg::t_dp_stat   o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ikhs_pkg::t_out       o_out
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int KEY_W   = ikhs_pkg::KEY_W;
    localparam int HASH_W  = ikhs_pkg::HASH_W;
    localparam int ENT_W   = KEY_W + LINK_W;
    localparam int RED_S   = HASH_W + SLOT_W;
    localparam int RECIP_W = HASH_W + 1;
    localparam int PROD_W  = HASH_W + RECIP_W;
    localparam int OSLOT_W  = ikhs_pkg::OSLOT_W;
    localparam int OCOUNT_W = ikhs_pkg::OCOUNT_W;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RED_S) / CAPACITY);

    localparam logic [1:0] RED_QUO = 2'd2;
    localparam logic [1:0] RED_SUB = 2'd1;
    localparam logic [1:0] RED_FIX = 2'd0;

    logic [ikhs_pkg::OP_W-1:0] r_op;
    logic [KEY_W-1:0]          r_key;
    logic [HASH_W-1:0]         r_rem;
    logic [HASH_W-1:0]         r_quo;
    logic [1:0]                r_red_k;
    logic [LINK_W-1:0]         r_link;
    logic [LINK_W-1:0]         r_head_link;
    logic [SLOT_W-1:0]         r_hit_slot;
    logic [COUNT_W-1:0]        r_count;
    logic [SLOT_W-1:0]         r_clr_idx;
    logic [LINK_W-1:0]         r_head_q;
    logic [ENT_W-1:0]          r_ent_q;
    logic                      r_out_valid;
    ikhs_pkg::t_out            r_out;

    logic [LINK_W-1:0] r_head_mem [CAPACITY];
    logic [ENT_W-1:0]  r_ent_mem  [CAPACITY];

    logic [HASH_W-1:0]          hash_val;
    logic [PROD_W-1:0]          red_prod;
    logic [HASH_W-1:0]          red_back;
    logic [SLOT_W-1:0]          bucket;
    logic [SLOT_W-1:0]          ins_slot;
    logic [OSLOT_W+SLOT_W-1:0]  slot_ext;
    logic [OCOUNT_W+COUNT_W-1:0] count_ext;
    logic                       slot_shown;

    // Hash of the latched key: rule * 37 + dot.
    assign hash_val = HASH_W'(r_key[KEY_W-1:ikhs_pkg::DOT_W]) * HASH_W'(ikhs_pkg::HASH_MULT)
                    + HASH_W'(r_key[ikhs_pkg::DOT_W-1:0]);

    // Bucket modulo in three steps: a reciprocal quotient that is at most one short,
    // multiply back and subtract, then one conditional subtract of the bucket count.
    assign red_prod = PROD_W'(r_rem) * PROD_W'(RECIP);
    assign red_back = r_quo * HASH_W'(CAPACITY);

    assign bucket   = r_rem[SLOT_W-1:0];
    assign ins_slot = r_count[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_in.operation;
            r_key <= {i_in.rule_index, i_in.dot_position};
        end
        if (i_cmd.hash_ld) begin
            r_rem   <= hash_val;
            r_red_k <= RED_QUO;
        end else if (i_cmd.red_step) begin
            if (r_red_k == RED_QUO) begin
                r_quo <= HASH_W'(red_prod >> RED_S);
            end else if (r_red_k == RED_SUB) begin
                r_rem <= r_rem - red_back;
            end else if (r_rem >= HASH_W'(CAPACITY)) begin
                r_rem <= r_rem - HASH_W'(CAPACITY);
            end
            r_red_k <= r_red_k - 2'd1;
        end
        if (i_cmd.link_from_head) begin
            r_link      <= r_head_q;
            r_head_link <= r_head_q;
        end else if (i_cmd.link_from_ent) begin
            r_link <= r_ent_q[LINK_W-1:0];
        end
        if (i_cmd.hit_ld) begin
            r_hit_slot <= r_link[SLOT_W-1:0];
        end else if (i_cmd.ins_wr) begin
            r_hit_slot <= ins_slot;
        end
    end

    // Bucket head memory: one write port shared by insert and the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_head_mem[bucket] <= {1'b1, ins_slot};
        end else if (i_cmd.clr_wr) begin
            r_head_mem[r_clr_idx] <= '0;
        end
        if (i_cmd.head_rd) begin
            r_head_q <= r_head_mem[bucket];
        end
    end

    // Entry memory: stored key and chain link of each slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_ent_mem[ins_slot] <= {r_key, r_head_link};
        end
        if (i_cmd.ent_rd) begin
            r_ent_q <= r_ent_mem[r_link[SLOT_W-1:0]];
        end
    end

    assign slot_shown = (i_cmd.status == ikhs_pkg::ST_INSERTED)
                     || (i_cmd.status == ikhs_pkg::ST_FOUND);
    assign slot_ext   = {{OSLOT_W{1'b0}}, (slot_shown ? r_hit_slot : SLOT_W'(0))};
    assign count_ext  = {{OCOUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.ins_wr) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.clr_start) begin
                r_clr_idx <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + SLOT_W'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out.status      <= i_cmd.status;
            r_out.slot        <= slot_ext[OSLOT_W-1:0];
            r_out.entry_count <= count_ext[OCOUNT_W-1:0];
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.red_last   = (r_red_k == RED_FIX);
    assign o_stat.link_valid = r_link[LINK_W-1];
    assign o_stat.key_match  = (r_ent_q[ENT_W-1:LINK_W] == r_key);
    assign o_stat.full       = (r_count >= COUNT_W'(CAPACITY));
    assign o_stat.clr_last   = (r_clr_idx == SLOT_W'(CAPACITY - 1));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/ikhs_ctrl.sv =====
// Controller state machine of the key hash set.
module ikhs_ctrl #(
    parameter int CAPACITY = ikhs_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output ikhs_pkg::t_ctrl_cmd  o_cmd,
    input  ikhs_pkg::t_dp_stat   i_stat
);

    localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_REDUCE = 4'd3;
    localparam logic [3:0] S_HEAD   = 4'd4;
    localparam logic [3:0] S_HLINK  = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_ENT    = 4'd7;
    localparam logic [3:0] S_INS    = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0]                    r_state, n_state;
    logic [ikhs_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_clr_report, n_clr_report;
    logic                          is_insert;

    assign is_insert  = (i_stat.op == ikhs_pkg::OP_INSERT);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = r_status;
        n_state      = r_state;
        n_status     = r_status;
        n_clr_report = r_clr_report;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.count_clr = 1'b1;
                    n_status        = ikhs_pkg::ST_CLEARED;
                    n_state         = r_clr_report ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.op == ikhs_pkg::OP_CLEAR) begin
                    o_cmd.clr_start = 1'b1;
                    n_clr_report    = 1'b1;
                    n_state         = S_CLEAR;
                end else begin
                    o_cmd.hash_ld = 1'b1;
                    n_state       = IS_POW2 ? S_HEAD : S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (i_stat.red_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HLINK;
            end
            S_HLINK: begin
                o_cmd.link_from_head = 1'b1;
                n_state              = S_LINK;
            end
            S_LINK: begin
                if (i_stat.link_valid) begin
                    o_cmd.ent_rd = 1'b1;
                    n_state      = S_ENT;
                end else if (is_insert) begin
                    n_state = S_INS;
                end else begin
                    n_status = ikhs_pkg::ST_NOT_FOUND;
                    n_state  = S_RESULT;
                end
            end
            S_ENT: begin
                if (i_stat.key_match) begin
                    o_cmd.hit_ld = 1'b1;
                    n_status     = is_insert ? ikhs_pkg::ST_DUPLICATE : ikhs_pkg::ST_FOUND;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.link_from_ent = 1'b1;
                    n_state             = S_LINK;
                end
            end
            S_INS: begin
                if (i_stat.full) begin
                    n_status = ikhs_pkg::ST_FULL;
                end else begin
                    o_cmd.ins_wr = 1'b1;
                    n_status     = ikhs_pkg::ST_INSERTED;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_report <= 1'b0;
            r_status     <= ikhs_pkg::ST_CLEARED;
        end else begin
            r_state      <= n_state;
            r_clr_report <= (n_state == S_IDLE) ? 1'b0 : n_clr_report;
            r_status     <= n_status;
        end
    end

endmodule

// ===== rtl/item_key_hash_set.sv =====
// Top level of the key hash set: controller, datapath and assertions.
// A find or insert hashes the key, reads the bucket head and then walks the chain link by link;
// a hit or an empty link ends the walk, and an insert of a new key then writes the entry if a slot is free.
// A CAPACITY that is not a power of two adds the bucket modulo steps after the hash.
// A clear sweeps all bucket heads; a new beat can be taken in the same cycle that a result shows.
// After reset a sweep clears the bucket heads, with no input taken.
module item_key_hash_set #(
    parameter int CAPACITY = ikhs_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ikhs_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ikhs_pkg::t_out  o_out
);

    `include "item_key_hash_set_assert.svh"

    // The controller walks one bucket chain per beat. It issues memory reads
    // and writes and the other datapath commands and picks the result status;
    // all keys, links, the entry count and the memories sit in the datapath.
    ikhs_pkg::t_ctrl_cmd cmd;
    ikhs_pkg::t_dp_stat  stat;

    // The controller takes a new beat whenever it is idle, even while the
    // previous result still waits in the output register. It only stalls
    // when it has a new result and that register is still occupied.
    ikhs_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Each new entry takes the slot equal to the count before the insert and
    // becomes the head of its bucket chain. The old head goes into the new
    // entry's link, so chains only ever point at slots written since the last
    // clear.
    ikhs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // The block works on one beat at a time, so an accepted beat drops ready at once.
    `IKHS_ASSERT_NEXT(a_one_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "busy")
    // An insert may only write when there is still a free slot.
    `IKHS_ASSERT_IMPLY(a_no_overfill, i_clk, i_rst_n, cmd.ins_wr, !stat.full, "overfill")
    // A result is loaded only when the output register is free, and then shows.
    `IKHS_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, cmd.out_ld, !stat.out_busy, "overwrite")
    `IKHS_ASSERT_NEXT(a_result_shows, i_clk, i_rst_n, cmd.out_ld, o_out_valid, "not shown")

endmodule
